// ===== rtl/core/priority_queue_sorted_insert_top_macros.svh =====
// Assertion shorthands for the sorted queue RTL.
`ifndef PRIORITY_QUEUE_SORTED_INSERT_TOP_MACROS_SVH
`define PRIORITY_QUEUE_SORTED_INSERT_TOP_MACROS_SVH

// Same-cycle implication.
`define PQSI_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PQSI_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/pqsi_pkg.sv =====
package pqsi_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int VALUE_W = 32;
   localparam int PRI_W = 16;
   localparam int COUNT_FIELD_W = 5;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef struct packed {
      op_type                    operation;
      logic signed [VALUE_W-1:0] item_value;
      logic signed [PRI_W-1:0]   item_priority;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] head_value;
      logic                      head_valid;
      logic                      error_flag;
      logic [COUNT_FIELD_W-1:0]  entry_count;
   } rsp_type;

   // Broadcast to every cell in the chain.
   typedef struct packed {
      logic                      insert;
      logic                      remove;
      logic signed [VALUE_W-1:0] value;
      logic signed [PRI_W-1:0]   pri;
   } cell_ctrl_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic signed [PRI_W-1:0]   pri;
   } entry_type;

endpackage

// ===== rtl/core/pqsi_cell.sv =====
module pqsi_cell import pqsi_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          occupied,
   input  logic          left_ahead,
   input  entry_type     left_entry,
   input  entry_type     right_entry,
   output entry_type     entry,
   output logic          ahead
);

   entry_type entry_ff;
   entry_type entry_in;

   // Held entry stays in front of the new one on equal priority (arrival order).
   assign ahead = occupied && ($signed(entry_ff.pri) <= $signed(ctrl.pri));
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.insert) begin
         if (!ahead) begin
            if (left_ahead) begin
               entry_in.value = ctrl.value;
               entry_in.pri   = ctrl.pri;
            end else begin
               entry_in = left_entry;
            end
         end
      end else if (ctrl.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== rtl/core/priority_queue_sorted_insert_top.sv =====
// Sorted priority queue built as a chain of compare-and-shift cells.
// Each rsp beat is registered and appears in the cycle after its req beat is accepted.
// Throughput: one item per cycle while rsp is taken; every cell compares and
// shifts in the same cycle, so the whole chain updates at once on insert or remove.
// Reset clears the entry count and rsp valid; the rsp payload and cell storage are not reset.
`include "priority_queue_sorted_insert_top_macros.svh"

module priority_queue_sorted_insert_top import pqsi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   logic             req_fire;
   logic             full;
   logic             empty;
   logic             err;
   cell_ctrl_type    ctrl;

   entry_type        entries [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] aheads;
   logic [QUEUE_DEPTH-1:0] occupied;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign err       = (req.operation == OP_INSERT) ? full : empty;

   always_comb begin
      ctrl.insert = req_fire && !err && (req.operation == OP_INSERT);
      ctrl.remove = req_fire && !err && (req.operation == OP_REMOVE);
      ctrl.value  = req.item_value;
      ctrl.pri    = req.item_priority;
   end

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         logic      left_ahead;
         entry_type left_entry;
         entry_type right_entry;

         assign occupied[gi] = (CNT_W'(gi) < count_ff);

         if (gi == 0) begin : g_first
            assign left_ahead = 1'b1;
            assign left_entry = '0;
         end else begin : g_mid
            assign left_ahead = aheads[gi-1];
            assign left_entry = entries[gi-1];
         end

         if (gi == QUEUE_DEPTH - 1) begin : g_last
            assign right_entry = '0;
         end else begin : g_inner
            assign right_entry = entries[gi+1];
         end

         pqsi_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .occupied    (occupied[gi]),
            .left_ahead  (left_ahead),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (entries[gi]),
            .ahead       (aheads[gi])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      priority if (ctrl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.remove) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_in             = rsp_ff;
      rsp_valid_in       = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         rsp_valid_in       = 1'b1;
         rsp_in.head_valid  = ctrl.remove;
         rsp_in.head_value  = ctrl.remove ? entries[0].value : '0;
         rsp_in.error_flag  = err;
         rsp_in.entry_count = COUNT_FIELD_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `PQSI_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH), "count over depth")
   `PQSI_ASSERT_IMP(a_flags_excl, rsp_valid, !(rsp.head_valid && rsp.error_flag), "valid and error")
   `PQSI_ASSERT_IMP(a_head_sorted, occupied[1], $signed(entries[0].pri) <= $signed(entries[1].pri), "head out of order")
   `PQSI_ASSERT_NXT(a_err_hold, req_fire && err, rsp_valid && rsp.error_flag && $stable(count_ff), "error changed count")
   `PQSI_ASSERT_NXT(a_remove_count, ctrl.remove, count_ff == $past(count_ff) - CNT_W'(1), "remove count slip")

endmodule
